// ===== hdl/csct_pkg.sv =====
`default_nettype none

package csct_pkg;

   // Coordinate width; every internal width below follows from it.
   localparam int COORD_BITS = 16;
   localparam int RAD_BITS   = COORD_BITS - 1;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int Q_W        = SUM_W + 2;
   localparam int MAG_W      = 2 * COORD_BITS + 2;
   localparam int HALF_W     = MAG_W / 2;
   localparam int PP_W       = 2 * HALF_W;
   localparam int SQ_W       = 2 * MAG_W;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [RAD_BITS-1:0]   radius_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [Q_W-1:0]        q_type;
   typedef logic        [MAG_W-1:0]      mag_type;
   typedef logic        [HALF_W-1:0]     half_type;
   typedef logic        [PP_W-1:0]       pp_type;
   typedef logic        [SQ_W-1:0]       sq_type;

   // Control that travels with an item once the quadratic's coefficients are known.
   typedef struct packed {
      logic valid;
      logic use_disc;
      logic early_hit;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hdl/csct_if.sv =====
`default_nettype none

interface csct_req_if;
   logic                   valid;
   logic                   ready;
   csct_pkg::coord_type    center_x;
   csct_pkg::coord_type    center_y;
   csct_pkg::radius_type   circle_radius;
   csct_pkg::coord_type    seg_start_x;
   csct_pkg::coord_type    seg_start_y;
   csct_pkg::coord_type    seg_end_x;
   csct_pkg::coord_type    seg_end_y;

   modport source (
      output valid, center_x, center_y, circle_radius,
             seg_start_x, seg_start_y, seg_end_x, seg_end_y,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, circle_radius,
             seg_start_x, seg_start_y, seg_end_x, seg_end_y,
      output ready
   );
endinterface

interface csct_rsp_if;
   logic valid;
   logic ready;
   logic crosses;

   modport source (output valid, crosses, input ready);
   modport sink (input valid, crosses, output ready);
endinterface

`default_nettype wire

// ===== hdl/csct_disc.sv =====
`default_nettype none

// Decides h*h >= a*c on magnitudes over three stages: half-width partial
// products, two wide sums, one compare.
module csct_disc (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire csct_pkg::ctl_type ctl_in,
   input  wire csct_pkg::mag_type h_mag,
   input  wire csct_pkg::mag_type a_mag,
   input  wire csct_pkg::mag_type c_mag,
   output csct_pkg::ctl_type      ctl_out,
   output logic                   disc_ge
);

   csct_pkg::ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   csct_pkg::pp_type  hh_ff, hl_ff, ll_ff, ahch_ff, ahcl_ff, alch_ff, alcl_ff;
   csct_pkg::pp_type  hh_in, hl_in, ll_in, ahch_in, ahcl_in, alch_in, alcl_in;
   csct_pkg::sq_type  hsq_ff, ac_ff, hsq_in, ac_in;
   logic              ge_ff, ge_in;
   csct_pkg::half_type h_hi, h_lo, a_hi, a_lo, c_hi, c_lo;

   assign h_hi = h_mag[csct_pkg::MAG_W-1:csct_pkg::HALF_W];
   assign h_lo = h_mag[csct_pkg::HALF_W-1:0];
   assign a_hi = a_mag[csct_pkg::MAG_W-1:csct_pkg::HALF_W];
   assign a_lo = a_mag[csct_pkg::HALF_W-1:0];
   assign c_hi = c_mag[csct_pkg::MAG_W-1:csct_pkg::HALF_W];
   assign c_lo = c_mag[csct_pkg::HALF_W-1:0];

   always_comb begin
      hh_in   = csct_pkg::pp_type'(h_hi) * csct_pkg::pp_type'(h_hi);
      hl_in   = csct_pkg::pp_type'(h_hi) * csct_pkg::pp_type'(h_lo);
      ll_in   = csct_pkg::pp_type'(h_lo) * csct_pkg::pp_type'(h_lo);
      ahch_in = csct_pkg::pp_type'(a_hi) * csct_pkg::pp_type'(c_hi);
      ahcl_in = csct_pkg::pp_type'(a_hi) * csct_pkg::pp_type'(c_lo);
      alch_in = csct_pkg::pp_type'(a_lo) * csct_pkg::pp_type'(c_hi);
      alcl_in = csct_pkg::pp_type'(a_lo) * csct_pkg::pp_type'(c_lo);
   end

   // The cross term of the square appears twice, hence the extra shift.
   always_comb begin
      hsq_in = (csct_pkg::sq_type'(hh_ff) << csct_pkg::MAG_W)
             + (csct_pkg::sq_type'(hl_ff) << (csct_pkg::HALF_W + 1))
             + csct_pkg::sq_type'(ll_ff);
      ac_in  = (csct_pkg::sq_type'(ahch_ff) << csct_pkg::MAG_W)
             + ((csct_pkg::sq_type'(ahcl_ff) + csct_pkg::sq_type'(alch_ff))
                << csct_pkg::HALF_W)
             + csct_pkg::sq_type'(alcl_ff);
      ge_in  = (hsq_ff >= ac_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (enable) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         ahch_ff <= ahch_in;
         ahcl_ff <= ahcl_in;
         alch_ff <= alch_in;
         alcl_ff <= alcl_in;
         hsq_ff  <= hsq_in;
         ac_ff   <= ac_in;
         ge_ff   <= ge_in;
      end
   end

   assign ctl_out = ctl3_ff;
   assign disc_ge = ge_ff;

   a_frozen_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(ctl1_ff) && $stable(ctl2_ff) && $stable(ctl3_ff))
      else $error("discriminant pipeline moved while stalled");

   a_early_excludes_disc: assert property (@(posedge clock) disable iff (reset)
      ctl1_ff.use_disc |-> !ctl1_ff.early_hit && ctl1_ff.valid)
      else $error("item marked both for early decision and discriminant");

   a_ctl_follows: assert property (@(posedge clock) disable iff (reset)
      enable |=> ctl1_ff == $past(ctl_in))
      else $error("control word lost entering discriminant pipeline");

endmodule

`default_nettype wire

// ===== hdl/circle_segment_crossing_test_unit.sv =====
`default_nettype none

// Circle / segment crossing test.
// Each word on req_bus carries a circle (center_x, center_y, circle_radius)
// and a segment (seg_start_*, seg_end_*). For each accepted word one word
// appears on rsp_bus whose crosses bit is set when the circle boundary meets
// the segment, tangency included. A segment wholly inside the circle and a
// degenerate segment (both endpoints equal) give 0. All arithmetic is exact.
// Throughput: one word per clock while the receiver keeps up. The result is
// shown on rsp_bus after the word passes a seven-stage
// pipeline (differences, products, coefficients, decision, then three
// stages for the squared discriminant compare on split 17-bit multipliers).
// Results leave through an output register backed by a skid register. When
// the receiver stalls, the skid register catches the next result and the
// whole pipeline then holds, dropping req_bus.ready, with nothing lost.
// Reset (synchronous, active high) clears all valid bits; no results are
// pending afterward and the block accepts a word in the first cycle.
module circle_segment_crossing_test_unit (
   input wire logic   clock,
   input wire logic   reset,
   csct_req_if.sink   req_bus,
   csct_rsp_if.source rsp_bus
);

   logic enable;

   // Stage 1: differences.
   logic                 s1_valid_ff;
   csct_pkg::diff_type   dx_ff, dy_ff, fx_ff, fy_ff, r_ff;
   csct_pkg::diff_type   dx_in, dy_in, fx_in, fy_in, r_in;

   // Stage 2: products.
   logic                 s2_valid_ff;
   csct_pkg::prod_type   dxdx_ff, dydy_ff, fxdx_ff, fydy_ff, fxfx_ff, fyfy_ff, rr_ff;

   // Stage 3: coefficients of q(t) = a t^2 + 2h t + c.
   logic                 s3_valid_ff;
   csct_pkg::sum_type    a_ff, h_ff, c_ff, a_in, h_in, c_in;

   // Stage 4: endpoint and vertex decision.
   csct_pkg::ctl_type    s4_ctl_ff, s4_ctl_in;
   csct_pkg::mag_type    hmag_ff, amag_ff, cmag_ff;
   csct_pkg::q_type      q1;
   csct_pkg::sum_type    h_plus_a;
   logic                 c_neg, c_le, q1_neg, q1_le, vertex_in, degenerate;

   // Discriminant stages.
   csct_pkg::ctl_type    d_ctl;
   logic                 d_ge;

   // Output register and skid register.
   logic                 out_valid_ff, out_valid_in, out_hit_ff, out_hit_in;
   logic                 skid_valid_ff, skid_valid_in, skid_hit_ff, skid_hit_in;
   logic                 push, push_hit;

   assign enable        = !skid_valid_ff;
   assign req_bus.ready = enable;

   always_comb begin
      dx_in = $signed({req_bus.seg_end_x[csct_pkg::COORD_BITS-1], req_bus.seg_end_x})
            - $signed({req_bus.seg_start_x[csct_pkg::COORD_BITS-1], req_bus.seg_start_x});
      dy_in = $signed({req_bus.seg_end_y[csct_pkg::COORD_BITS-1], req_bus.seg_end_y})
            - $signed({req_bus.seg_start_y[csct_pkg::COORD_BITS-1], req_bus.seg_start_y});
      fx_in = $signed({req_bus.seg_start_x[csct_pkg::COORD_BITS-1], req_bus.seg_start_x})
            - $signed({req_bus.center_x[csct_pkg::COORD_BITS-1], req_bus.center_x});
      fy_in = $signed({req_bus.seg_start_y[csct_pkg::COORD_BITS-1], req_bus.seg_start_y})
            - $signed({req_bus.center_y[csct_pkg::COORD_BITS-1], req_bus.center_y});
      r_in  = $signed({2'b00, req_bus.circle_radius});
   end

   always_comb begin
      a_in = csct_pkg::sum_type'(dxdx_ff) + csct_pkg::sum_type'(dydy_ff);
      h_in = csct_pkg::sum_type'(fxdx_ff) + csct_pkg::sum_type'(fydy_ff);
      c_in = csct_pkg::sum_type'(fxfx_ff) + csct_pkg::sum_type'(fyfy_ff)
           - csct_pkg::sum_type'(rr_ff);
   end

   // q(0) = c and q(1) = a + 2h + c. With both endpoints strictly inside the
   // segment misses; with either on or inside the boundary it hits. Failing
   // both, a root can only lie between them if the vertex does.
   always_comb begin
      q1         = csct_pkg::q_type'(a_ff) + csct_pkg::q_type'(c_ff)
                 + (csct_pkg::q_type'(h_ff) <<< 1);
      h_plus_a   = h_ff + a_ff;
      c_neg      = c_ff[csct_pkg::SUM_W-1];
      c_le       = c_neg || (c_ff == '0);
      q1_neg     = q1[csct_pkg::Q_W-1];
      q1_le      = q1_neg || (q1 == '0);
      vertex_in  = (h_ff[csct_pkg::SUM_W-1] || (h_ff == '0))
                   && !h_plus_a[csct_pkg::SUM_W-1];
      degenerate = (a_ff == '0);
      // Bubbles carry stale data, so both decision flags follow the valid bit.
      s4_ctl_in.valid     = s3_valid_ff;
      s4_ctl_in.early_hit = s3_valid_ff && !degenerate && !(c_neg && q1_neg)
                            && (c_le || q1_le);
      s4_ctl_in.use_disc  = s3_valid_ff && !degenerate && !c_le && !q1_le
                            && vertex_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ctl_ff   <= '0;
      end else if (enable) begin
         s1_valid_ff <= req_bus.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_ctl_ff   <= s4_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         fx_ff   <= fx_in;
         fy_ff   <= fy_in;
         r_ff    <= r_in;
         dxdx_ff <= csct_pkg::prod_type'(dx_ff) * csct_pkg::prod_type'(dx_ff);
         dydy_ff <= csct_pkg::prod_type'(dy_ff) * csct_pkg::prod_type'(dy_ff);
         fxdx_ff <= csct_pkg::prod_type'(fx_ff) * csct_pkg::prod_type'(dx_ff);
         fydy_ff <= csct_pkg::prod_type'(fy_ff) * csct_pkg::prod_type'(dy_ff);
         fxfx_ff <= csct_pkg::prod_type'(fx_ff) * csct_pkg::prod_type'(fx_ff);
         fyfy_ff <= csct_pkg::prod_type'(fy_ff) * csct_pkg::prod_type'(fy_ff);
         rr_ff   <= csct_pkg::prod_type'(r_ff) * csct_pkg::prod_type'(r_ff);
         a_ff    <= a_in;
         h_ff    <= h_in;
         c_ff    <= c_in;
         // Magnitudes are only used when h <= 0 and c > 0.
         hmag_ff <= csct_pkg::mag_type'(-h_ff);
         amag_ff <= csct_pkg::mag_type'(a_ff);
         cmag_ff <= csct_pkg::mag_type'(c_ff);
      end
   end

   csct_disc u_disc (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .ctl_in  (s4_ctl_ff),
      .h_mag   (hmag_ff),
      .a_mag   (amag_ff),
      .c_mag   (cmag_ff),
      .ctl_out (d_ctl),
      .disc_ge (d_ge)
   );

   assign push     = enable && d_ctl.valid;
   assign push_hit = d_ctl.use_disc ? d_ge : d_ctl.early_hit;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_hit_in    = out_hit_ff;
      skid_valid_in = skid_valid_ff;
      skid_hit_in   = skid_hit_ff;
      if (!out_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_hit_in    = skid_hit_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_hit_in   = push_hit;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_hit_in   = push_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_hit_ff  <= out_hit_in;
      skid_hit_ff <= skid_hit_in;
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.crosses = out_hit_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_bus.ready |=> skid_valid_ff && $stable(s4_ctl_ff)
                                          && $stable(s3_valid_ff))
      else $error("pipeline advanced while results were backed up");

   a_disc_needs_positive_c: assert property (@(posedge clock) disable iff (reset)
      s4_ctl_ff.use_disc |-> cmag_ff != '0 && amag_ff != '0)
      else $error("discriminant requested with c or a not positive");

endmodule

`default_nettype wire

// ===== sim/crossing_sb_pkg.sv =====
package crossing_sb_pkg;

   typedef struct packed {
      csct_pkg::coord_type  center_x;
      csct_pkg::coord_type  center_y;
      csct_pkg::radius_type circle_radius;
      csct_pkg::coord_type  seg_start_x;
      csct_pkg::coord_type  seg_start_y;
      csct_pkg::coord_type  seg_end_x;
      csct_pkg::coord_type  seg_end_y;
   } crossing_query_type;

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic crossing_query_type build_query(int cx, int cy, int r,
                                                      int sx, int sy, int ex, int ey);
      crossing_query_type q;
      q.center_x      = csct_pkg::coord_type'(cx);
      q.center_y      = csct_pkg::coord_type'(cy);
      q.circle_radius = csct_pkg::radius_type'(r);
      q.seg_start_x   = csct_pkg::coord_type'(sx);
      q.seg_start_y   = csct_pkg::coord_type'(sy);
      q.seg_end_x     = csct_pkg::coord_type'(ex);
      q.seg_end_y     = csct_pkg::coord_type'(ey);
      return q;
   endfunction

   function automatic int extreme_coord();
      case (pick(0, 5))
         0: return -32768;
         1: return -1;
         2: return 0;
         3: return 1;
         4: return 32767;
         default: return pick(-32768, 32767);
      endcase
   endfunction

   // Most words are built around the circle so that both branches of the
   // decision and the exact boundary cases are reached often.
   function automatic crossing_query_type make_query();
      int cx, cy, r, k, sgx, sgy, m1, m2, span, px, py, sel;
      crossing_query_type q;
      sel = pick(0, 99);
      if (sel < 15) begin
         q = crossing_query_type'({$urandom, $urandom, $urandom, $urandom});
      end else if (sel < 50) begin
         cx = pick(-12000, 12000);
         cy = pick(-12000, 12000);
         r = pick(0, 1) ? pick(0, 60) : pick(0, 8000);
         span = r + r / 4 + 3;
         q = build_query(cx, cy, r, cx + pick(-span, span), cy + pick(-span, span),
                         cx + pick(-span, span), cy + pick(-span, span));
      end else if (sel < 65) begin
         // Tangent line through a 3-4-5 point, perpendicular to the radius.
         cx = pick(-10000, 10000);
         cy = pick(-10000, 10000);
         k = pick(0, 2000);
         sgx = pick(0, 1) ? 1 : -1;
         sgy = pick(0, 1) ? 1 : -1;
         px = cx + 3 * k * sgx;
         py = cy + 4 * k * sgy;
         m1 = pick(-2000, 2000);
         m2 = pick(0, 3) == 0 ? -m1 : pick(-2000, 2000);
         q = build_query(cx, cy, 5 * k, px + 4 * m1 * sgy, py - 3 * m1 * sgx,
                         px + 4 * m2 * sgy, py - 3 * m2 * sgx);
      end else if (sel < 75) begin
         q = build_query(pick(-8, 8), pick(-8, 8), pick(0, 8), pick(-8, 8), pick(-8, 8),
                         pick(-8, 8), pick(-8, 8));
      end else if (sel < 85) begin
         // One endpoint exactly on the boundary.
         cx = pick(-10000, 10000);
         cy = pick(-10000, 10000);
         k = pick(1, 2000);
         sgx = pick(0, 1) ? 1 : -1;
         sgy = pick(0, 1) ? 1 : -1;
         px = cx + 3 * k * sgx;
         py = cy + 4 * k * sgy;
         span = 2 * k + 5;
         m1 = px + pick(-span, span);
         m2 = py + pick(-span, span);
         if (pick(0, 1))
            q = build_query(cx, cy, 5 * k, px, py, m1, m2);
         else
            q = build_query(cx, cy, 5 * k, m1, m2, px, py);
      end else if (sel < 90) begin
         px = pick(-32768, 32767);
         py = pick(-32768, 32767);
         q = build_query(pick(-32768, 32767), pick(-32768, 32767), pick(0, 32767),
                         px, py, px, py);
      end else if (sel < 95) begin
         cx = pick(-10000, 10000);
         cy = pick(-10000, 10000);
         r = pick(100, 20000);
         span = r / 2;
         q = build_query(cx, cy, r, cx + pick(-span, span), cy + pick(-span, span),
                         cx + pick(-span, span), cy + pick(-span, span));
      end else begin
         case (pick(0, 3))
            0: r = 0;
            1: r = 1;
            2: r = 32767;
            default: r = pick(0, 32767);
         endcase
         q = build_query(extreme_coord(), extreme_coord(), r, extreme_coord(),
                         extreme_coord(), extreme_coord(), extreme_coord());
      end
      return q;
   endfunction

   class crossing_scoreboard;
      bit expected_crosses[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      // Exact integer test: q(t) = a t^2 + 2h t + c over t in [0,1].
      function bit predict_crossing(crossing_query_type w);
         longint dx, dy, fx, fy, rad, a, h, c, q1;
         logic signed [127:0] hw, aw, cw, disc;
         dx = longint'(w.seg_end_x) - longint'(w.seg_start_x);
         dy = longint'(w.seg_end_y) - longint'(w.seg_start_y);
         fx = longint'(w.seg_start_x) - longint'(w.center_x);
         fy = longint'(w.seg_start_y) - longint'(w.center_y);
         rad = longint'(w.circle_radius);
         if (dx == 0 && dy == 0)
            return 1'b0;
         a = dx * dx + dy * dy;
         h = fx * dx + fy * dy;
         c = fx * fx + fy * fy - rad * rad;
         q1 = a + 2 * h + c;
         if (c < 0 && q1 < 0)
            return 1'b0;
         if (c <= 0 || q1 <= 0)
            return 1'b1;
         if (h <= 0 && h + a >= 0) begin
            hw = h;
            aw = a;
            cw = c;
            disc = hw * hw - aw * cw;
            return disc >= 0;
         end
         return 1'b0;
      endfunction

      function void note_query(crossing_query_type w);
         expected_crosses = {expected_crosses, predict_crossing(w)};
      endfunction

      function int pending();
         return expected_crosses.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100)
            $display("MISMATCH: %s", msg);
      endtask

      task check_crosses(logic got);
         bit want;
         if (expected_crosses.size() == 0) begin
            report($sformatf("result word crosses=%b with no query outstanding", got));
         end else begin
            want = expected_crosses.pop_front();
            if (got !== want)
               report($sformatf("crosses=%b, expected %b", got, want));
         end
      endtask
   endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   bit   long_hold_request;

   csct_req_if req_bus ();
   csct_rsp_if rsp_bus ();

   circle_segment_crossing_test_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   crossing_sb_pkg::crossing_scoreboard sb = new();

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Presents one query and returns right after the edge that accepts it.
   task send_query(crossing_sb_pkg::crossing_query_type q);
      bit taken;
      req_bus.valid         <= 1'b1;
      req_bus.center_x      <= q.center_x;
      req_bus.center_y      <= q.center_y;
      req_bus.circle_radius <= q.circle_radius;
      req_bus.seg_start_x   <= q.seg_start_x;
      req_bus.seg_start_y   <= q.seg_start_y;
      req_bus.seg_end_x     <= q.seg_end_x;
      req_bus.seg_end_y     <= q.seg_end_y;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         if (taken)
            sb.note_query(q);
         @(posedge clock);
      end while (!taken);
   endtask

   task send_bursts(int count);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = crossing_sb_pkg::pick(0, 4) == 0 ? crossing_sb_pkg::pick(40, 120)
                                                 : crossing_sb_pkg::pick(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_query(crossing_sb_pkg::make_query());
            sent++;
         end
         if (crossing_sb_pkg::pick(0, 3) != 0) begin
            gap = crossing_sb_pkg::pick(1, 8);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Receiver: switches among random stall patterns, and holds
   // off entirely for a long stretch whenever the sender asks for it.
   initial begin
      int mode, mode_left, hold_left, cyc;
      rsp_bus.ready <= 1'b0;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = 300;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = crossing_sb_pkg::pick(0, 3);
               mode_left = crossing_sb_pkg::pick(50, 400);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= crossing_sb_pkg::pick(0, 3) != 0;
               2: rsp_bus.ready <= crossing_sb_pkg::pick(0, 9) < 3;
               default: rsp_bus.ready <= (cyc % 7) >= 3;
            endcase
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_crosses(rsp_bus.crosses);
   end

   initial begin
      long_hold_request = 1'b0;
      reset <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.center_x      <= '0;
      req_bus.center_y      <= '0;
      req_bus.circle_radius <= '0;
      req_bus.seg_start_x   <= '0;
      req_bus.seg_start_y   <= '0;
      req_bus.seg_end_x     <= '0;
      req_bus.seg_end_y     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Degenerate segment, segment inside the circle, a plain crossing.
      send_query(crossing_sb_pkg::build_query(0, 0, 5, 3, 3, 3, 3));
      send_query(crossing_sb_pkg::build_query(0, 0, 100, -10, 0, 10, 0));
      send_query(crossing_sb_pkg::build_query(0, 0, 10, -20, 0, 20, 0));
      // Tangency, axis aligned and along a 3-4-5 direction, then a near miss.
      send_query(crossing_sb_pkg::build_query(0, 0, 10, -20, 10, 20, 10));
      send_query(crossing_sb_pkg::build_query(0, 0, 5, -5, 10, 11, -2));
      send_query(crossing_sb_pkg::build_query(0, 0, 10, -20, 11, 20, 11));
      // Segment pointing away, starting on the circle, ending on it from inside.
      send_query(crossing_sb_pkg::build_query(0, 0, 10, 20, 0, 40, 0));
      send_query(crossing_sb_pkg::build_query(0, 0, 10, 10, 0, 30, 0));
      send_query(crossing_sb_pkg::build_query(0, 0, 10, 0, 0, 10, 0));
      // Zero radius: on the segment, off it, at an endpoint, degenerate.
      send_query(crossing_sb_pkg::build_query(5, 5, 0, 0, 0, 10, 10));
      send_query(crossing_sb_pkg::build_query(5, 6, 0, 0, 0, 10, 10));
      send_query(crossing_sb_pkg::build_query(0, 0, 0, 0, 0, 7, -3));
      send_query(crossing_sb_pkg::build_query(3, 3, 0, 3, 3, 3, 3));
      // Extremes of every field.
      send_query(crossing_sb_pkg::build_query(-32768, -32768, 32767, 32767, 32767,
                                              -32768, 32767));
      send_query(crossing_sb_pkg::build_query(32767, 32767, 32767, -32768, -32768,
                                              32767, -32768));
      send_query(crossing_sb_pkg::build_query(32767, 32767, 32767, 32767, -32768,
                                              -32768, 32767));
      send_query(crossing_sb_pkg::build_query(-32768, 32767, 0, -32768, 32767,
                                              32767, -32768));
      send_query(crossing_sb_pkg::build_query(0, 0, 32767, -32768, -32768,
                                              32767, 32767));
      send_query(crossing_sb_pkg::build_query(-1, -1, 1, -1, 0, 0, -1));
      send_query(crossing_sb_pkg::build_query(32767, -32768, 32767, 32767, -32768,
                                              32767, -32767));
      wait_drained();

      send_bursts(300);

      // The receiver holds off while words keep coming, so the pipeline fills.
      long_hold_request = 1'b1;
      for (int i = 0; i < 150; i++)
         send_query(crossing_sb_pkg::make_query());
      wait_drained();

      send_bursts(1480);
      wait_drained();
      repeat (20) @(posedge clock);

      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #4ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/csct_pkg.sv
hdl/csct_if.sv
hdl/csct_disc.sv
hdl/circle_segment_crossing_test_unit.sv
sim/crossing_sb_pkg.sv
sim/tb_top.sv
